>>> sv/tcm_pkg.sv
package tcm_pkg;

  localparam int unsigned RAW_BITS    = 12;
  localparam int unsigned SCREEN_BITS = 11;
  localparam int unsigned SIZE_BITS   = SCREEN_BITS + 1;
  localparam int unsigned CFG_BITS    = (RAW_BITS > SIZE_BITS) ? RAW_BITS : SIZE_BITS;
  localparam int unsigned PROD_BITS   = RAW_BITS + SIZE_BITS;
  localparam int unsigned IDX_BITS    = 3;

  localparam int unsigned ORI_SWAP     = 0;
  localparam int unsigned ORI_MIRROR_X = 1;
  localparam int unsigned ORI_MIRROR_Y = 2;

  localparam logic [RAW_BITS-1:0]  RAW_MIN_RST  = RAW_BITS'(0);
  localparam logic [RAW_BITS-1:0]  RAW_MAX_RST  = RAW_BITS'(4095);
  localparam logic [SIZE_BITS-1:0] WIDTH_RST    = SIZE_BITS'(320);
  localparam logic [SIZE_BITS-1:0] HEIGHT_RST   = SIZE_BITS'(240);

  typedef enum logic [IDX_BITS-1:0] {
    REG_RAW_MIN_X     = 3'd0,
    REG_RAW_MAX_X     = 3'd1,
    REG_RAW_MIN_Y     = 3'd2,
    REG_RAW_MAX_Y     = 3'd3,
    REG_SCREEN_WIDTH  = 3'd4,
    REG_SCREEN_HEIGHT = 3'd5,
    REG_ORIENTATION   = 3'd6
  } tcm_reg_e;

  typedef struct packed {
    logic [RAW_BITS-1:0] raw_x;
    logic [RAW_BITS-1:0] raw_y;
  } tcm_req_t;

  typedef struct packed {
    logic [SCREEN_BITS-1:0] pixel_x;
    logic [SCREEN_BITS-1:0] pixel_y;
  } tcm_res_t;

  // one axis after swap: offset from min, calibration span, effective size
  typedef struct packed {
    logic signed [RAW_BITS:0] num;
    logic signed [RAW_BITS:0] span;
    logic [SIZE_BITS-1:0]     size;
    logic                     mirror;
  } tcm_axis_t;

endpackage

>>> sv/touch_coordinate_mapper.sv
// Touch coordinate mapper: turns one raw touch sample into one screen pixel
// through a linear calibration per axis, with optional axis swap and mirror.
// A request is taken whenever start_i is high; busy_o stays low, so a new
// request may follow in every cycle. The result appears with a one-cycle
// valid_o strobe. It passes 28 register stages, the first loaded at the
// accepting edge: input register, multiplier, one divider stage per
// quotient bit of the 24-bit scaled offset, sign/mirror, and clamp. Most
// of these stages form the restoring divider pipeline. The receiver cannot
// stall: each result must be taken in the cycle it is shown. Calibration
// registers are written through the cfg port, which is always ready; write
// them only with no request in flight.
module touch_coordinate_mapper
  import tcm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  tcm_req_t            req_i,
  output logic                valid_o,
  output tcm_res_t            res_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [IDX_BITS-1:0] cfg_index_i,
  input  logic [CFG_BITS-1:0] cfg_data_i
);

  logic [RAW_BITS-1:0]  min_x_q, max_x_q, min_y_q, max_y_q;
  logic [SIZE_BITS-1:0] width_q, height_q;
  logic [2:0]           orient_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q  <= RAW_MIN_RST;
      max_x_q  <= RAW_MAX_RST;
      min_y_q  <= RAW_MIN_RST;
      max_y_q  <= RAW_MAX_RST;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      orient_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (tcm_reg_e'(cfg_index_i))
        REG_RAW_MIN_X:     min_x_q  <= cfg_data_i[RAW_BITS-1:0];
        REG_RAW_MAX_X:     max_x_q  <= cfg_data_i[RAW_BITS-1:0];
        REG_RAW_MIN_Y:     min_y_q  <= cfg_data_i[RAW_BITS-1:0];
        REG_RAW_MAX_Y:     max_y_q  <= cfg_data_i[RAW_BITS-1:0];
        REG_SCREEN_WIDTH:  width_q  <= cfg_data_i[SIZE_BITS-1:0];
        REG_SCREEN_HEIGHT: height_q <= cfg_data_i[SIZE_BITS-1:0];
        REG_ORIENTATION:   orient_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // size saturates to 1 .. 2^SCREEN_BITS
  function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] s);
    logic [SIZE_BITS-1:0] r;
    if (s[SIZE_BITS-1]) begin
      r = {1'b1, {SCREEN_BITS{1'b0}}};
    end else if (s == '0) begin
      r = SIZE_BITS'(1);
    end else begin
      r = s;
    end
    return r;
  endfunction

  logic                 swap;
  logic [RAW_BITS-1:0]  a, b, a_lo, a_hi, b_lo, b_hi;
  logic signed [RAW_BITS:0] a_span, b_span;
  tcm_axis_t            ax_d, ay_d, ax_q, ay_q;
  logic                 in_valid_q;

  always_comb begin
    swap   = orient_q[ORI_SWAP];
    a      = swap ? req_i.raw_y : req_i.raw_x;
    b      = swap ? req_i.raw_x : req_i.raw_y;
    a_lo   = swap ? min_y_q : min_x_q;
    a_hi   = swap ? max_y_q : max_x_q;
    b_lo   = swap ? min_x_q : min_y_q;
    b_hi   = swap ? max_x_q : max_y_q;
    a_span = $signed({1'b0, a_hi}) - $signed({1'b0, a_lo});
    b_span = $signed({1'b0, b_hi}) - $signed({1'b0, b_lo});

    ax_d.num    = $signed({1'b0, a}) - $signed({1'b0, a_lo});
    ax_d.span   = (a_span == '0) ? $signed({{RAW_BITS{1'b0}}, 1'b1}) : a_span;
    ax_d.size   = eff_size(width_q);
    ax_d.mirror = orient_q[ORI_MIRROR_X];

    ay_d.num    = $signed({1'b0, b}) - $signed({1'b0, b_lo});
    ay_d.span   = (b_span == '0) ? $signed({{RAW_BITS{1'b0}}, 1'b1}) : b_span;
    ay_d.size   = eff_size(height_q);
    ay_d.mirror = orient_q[ORI_MIRROR_Y];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q <= ax_d;
    ay_q <= ay_d;
  end

  logic x_valid, y_valid;

  tcm_axis u_axis_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .op_i    (ax_q),
    .valid_o (x_valid),
    .pix_o   (res_o.pixel_x)
  );

  tcm_axis u_axis_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .op_i    (ay_q),
    .valid_o (y_valid),
    .pix_o   (res_o.pixel_y)
  );

  assign valid_o = x_valid;

  a_axes_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    x_valid == y_valid)
    else $error("axis pipelines out of step");

endmodule

>>> sv/tcm_axis.sv
module tcm_axis
  import tcm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  tcm_axis_t              op_i,
  output logic                   valid_o,
  output logic [SCREEN_BITS-1:0] pix_o
);

  localparam int unsigned NS = PROD_BITS;
  localparam int unsigned VW = PROD_BITS + 3;

  // multiply stage operands
  logic signed [RAW_BITS:0] num_neg, span_neg;
  logic [RAW_BITS-1:0]      num_mag, span_mag;
  logic [PROD_BITS-1:0]     prod;

  always_comb begin
    num_neg  = -op_i.num;
    span_neg = -op_i.span;
    num_mag  = op_i.num[RAW_BITS]  ? num_neg[RAW_BITS-1:0]  : op_i.num[RAW_BITS-1:0];
    span_mag = op_i.span[RAW_BITS] ? span_neg[RAW_BITS-1:0] : op_i.span[RAW_BITS-1:0];
    prod     = {{SIZE_BITS{1'b0}}, num_mag} * {{RAW_BITS{1'b0}}, op_i.size};
  end

  // restoring divider, one quotient bit per stage; stage 0 is the product register
  logic                 v_q   [NS+1];
  logic [RAW_BITS-1:0]  rem_q [NS+1];
  logic [PROD_BITS-1:0] dq_q  [NS+1];
  logic [RAW_BITS-1:0]  dvs_q [NS+1];
  logic                 neg_q [NS+1];
  logic [SIZE_BITS-1:0] size_q[NS+1];
  logic                 mir_q [NS+1];

  logic [RAW_BITS:0]    trial [NS];
  logic [RAW_BITS:0]    diff  [NS];
  logic                 ge    [NS];
  logic [RAW_BITS-1:0]  rem_d [NS];
  logic [PROD_BITS-1:0] dq_d  [NS];

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      trial[k] = {rem_q[k], dq_q[k][PROD_BITS-1]};
      diff[k]  = trial[k] - {1'b0, dvs_q[k]};
      ge[k]    = trial[k] >= {1'b0, dvs_q[k]};
      rem_d[k] = ge[k] ? diff[k][RAW_BITS-1:0] : trial[k][RAW_BITS-1:0];
      dq_d[k]  = {dq_q[k][PROD_BITS-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NS; k++) v_q[k] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
      for (int k = 0; k < NS; k++) v_q[k+1] <= v_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= '0;
    dq_q[0]   <= prod;
    dvs_q[0]  <= span_mag;
    neg_q[0]  <= op_i.num[RAW_BITS] ^ op_i.span[RAW_BITS];
    size_q[0] <= op_i.size;
    mir_q[0]  <= op_i.mirror;
    for (int k = 0; k < NS; k++) begin
      rem_q[k+1]  <= rem_d[k];
      dq_q[k+1]   <= dq_d[k];
      dvs_q[k+1]  <= dvs_q[k];
      neg_q[k+1]  <= neg_q[k];
      size_q[k+1] <= size_q[k];
      mir_q[k+1]  <= mir_q[k];
    end
  end

  // sign and mirror
  logic signed [VW-1:0] q_mag, q_s, sz_s, v_d;
  logic signed [VW-1:0] f1_v_q;
  logic [SIZE_BITS-1:0] f1_size_q;
  logic                 f1_valid_q;

  always_comb begin
    q_mag = $signed({3'b000, dq_q[NS]});
    q_s   = neg_q[NS] ? -q_mag : q_mag;
    sz_s  = $signed({{(VW-SIZE_BITS){1'b0}}, size_q[NS]});
    v_d   = mir_q[NS] ? (sz_s - VW'(1) - q_s) : q_s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else begin
      f1_valid_q <= v_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    f1_v_q    <= v_d;
    f1_size_q <= size_q[NS];
  end

  // clamp to 0 .. size - 1
  logic signed [VW-1:0]   f1_sz_s;
  logic [SIZE_BITS-1:0]   size_m1;
  logic [SCREEN_BITS-1:0] pix_d, pix_q;
  logic                   valid_q;

  always_comb begin
    f1_sz_s = $signed({{(VW-SIZE_BITS){1'b0}}, f1_size_q});
    size_m1 = f1_size_q - SIZE_BITS'(1);
    if (f1_v_q < 0) begin
      pix_d = '0;
    end else if (f1_v_q >= f1_sz_s) begin
      pix_d = size_m1[SCREEN_BITS-1:0];
    end else begin
      pix_d = f1_v_q[SCREEN_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
  end

  assign valid_o = valid_q;
  assign pix_o   = pix_q;

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] |-> (dvs_q[0] != '0))
    else $error("zero divisor entered the divider");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS] |-> (rem_q[NS] < dvs_q[NS]))
    else $error("final remainder not below divisor");

  a_pix_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(f1_valid_q) |-> ({1'b0, pix_o} < $past(f1_size_q)))
    else $error("pixel beyond screen size");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tcm_pkg::*;

  localparam int RAW_TOP = (1 << RAW_BITS) - 1;
  localparam int TARGET_TOUCHES = 1150;
  localparam logic [IDX_BITS-1:0] REG_UNUSED = 3'd7;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  tcm_req_t            req_i = '0;
  logic                valid_o;
  tcm_res_t            res_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [IDX_BITS-1:0] cfg_index_i = '0;
  logic [CFG_BITS-1:0] cfg_data_i = '0;

  touch_coordinate_mapper dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .valid_o    (valid_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // calibration as the block should hold it
  logic [RAW_BITS-1:0]  cal_min_x = RAW_MIN_RST;
  logic [RAW_BITS-1:0]  cal_max_x = RAW_MAX_RST;
  logic [RAW_BITS-1:0]  cal_min_y = RAW_MIN_RST;
  logic [RAW_BITS-1:0]  cal_max_y = RAW_MAX_RST;
  logic [SIZE_BITS-1:0] scr_width = WIDTH_RST;
  logic [SIZE_BITS-1:0] scr_height = HEIGHT_RST;
  logic [2:0]           orient = '0;

  tcm_req_t pending_touches[$];
  tcm_res_t expected_pixels[$];
  tcm_res_t want_pixel;
  int       mismatch_count = 0;
  int       burst_left = 1;
  int       gap_left = 0;

  function automatic logic [SCREEN_BITS-1:0] scale_axis(input logic [RAW_BITS-1:0] raw,
                                                        input logic [RAW_BITS-1:0] lo,
                                                        input logic [RAW_BITS-1:0] hi,
                                                        input logic [SIZE_BITS-1:0] size_reg,
                                                        input logic mirror);
    longint pix_count;
    longint span;
    longint offset;
    longint v;
    pix_count = longint'(size_reg);
    if (pix_count < 1) pix_count = 1;
    if (pix_count > (longint'(1) << SCREEN_BITS)) pix_count = longint'(1) << SCREEN_BITS;
    span = longint'(hi);
    span = span - longint'(lo);
    if (span == 0) span = 1;
    offset = longint'(raw);
    offset = offset - longint'(lo);
    v = (offset * pix_count) / span;
    if (mirror) v = pix_count - 1 - v;
    if (v < 0) v = 0;
    if (v >= pix_count) v = pix_count - 1;
    return v[SCREEN_BITS-1:0];
  endfunction

  function automatic tcm_res_t predict_pixel(input tcm_req_t touch);
    tcm_res_t pix;
    if (orient[ORI_SWAP]) begin
      pix.pixel_x = scale_axis(touch.raw_y, cal_min_y, cal_max_y, scr_width,
                               orient[ORI_MIRROR_X]);
      pix.pixel_y = scale_axis(touch.raw_x, cal_min_x, cal_max_x, scr_height,
                               orient[ORI_MIRROR_Y]);
    end else begin
      pix.pixel_x = scale_axis(touch.raw_x, cal_min_x, cal_max_x, scr_width,
                               orient[ORI_MIRROR_X]);
      pix.pixel_y = scale_axis(touch.raw_y, cal_min_y, cal_max_y, scr_height,
                               orient[ORI_MIRROR_Y]);
    end
    return pix;
  endfunction

  function automatic logic [RAW_BITS-1:0] near_range(input logic [RAW_BITS-1:0] lo,
                                                     input logic [RAW_BITS-1:0] hi);
    int a;
    int b;
    a = ((lo < hi) ? int'(lo) : int'(hi)) - 16;
    b = ((lo < hi) ? int'(hi) : int'(lo)) + 16;
    if (a < 0) a = 0;
    if (b > RAW_TOP) b = RAW_TOP;
    return RAW_BITS'($urandom_range(b, a));
  endfunction

  function automatic logic [SIZE_BITS-1:0] pick_size();
    case ($urandom_range(0, 11))
      0: return SIZE_BITS'(0);
      1: return SIZE_BITS'(1);
      2: return SIZE_BITS'(2048);
      3: return SIZE_BITS'(4095);
      4: return SIZE_BITS'(2049);
      5: return SIZE_BITS'(2047);
      default: return SIZE_BITS'($urandom_range(2048, 1));
    endcase
  endfunction

  // sender: bursts of requests separated by random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) expected_pixels.push_back(predict_pixel(req_i));
      if (!(start_i && busy_o)) begin
        if (gap_left > 0) begin
          start_i <= 1'b0;
          gap_left--;
        end else if (pending_touches.size() != 0) begin
          start_i <= 1'b1;
          req_i <= pending_touches.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(24, 1);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(7, 1);
          end else begin
            burst_left--;
          end
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result: expected none, got (%0d, %0d)", $time,
                 res_o.pixel_x, res_o.pixel_y);
        mismatch_count++;
      end else begin
        want_pixel = expected_pixels.pop_front();
        if (res_o.pixel_x !== want_pixel.pixel_x) begin
          $display("%0t: pixel_x mismatch: expected %0d, got %0d", $time,
                   want_pixel.pixel_x, res_o.pixel_x);
          mismatch_count++;
        end
        if (res_o.pixel_y !== want_pixel.pixel_y) begin
          $display("%0t: pixel_y mismatch: expected %0d, got %0d", $time,
                   want_pixel.pixel_y, res_o.pixel_y);
          mismatch_count++;
        end
      end
    end
  end

  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input int data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_BITS'(data);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_RAW_MIN_X:     cal_min_x = data[RAW_BITS-1:0];
      REG_RAW_MAX_X:     cal_max_x = data[RAW_BITS-1:0];
      REG_RAW_MIN_Y:     cal_min_y = data[RAW_BITS-1:0];
      REG_RAW_MAX_Y:     cal_max_y = data[RAW_BITS-1:0];
      REG_SCREEN_WIDTH:  scr_width = data[SIZE_BITS-1:0];
      REG_SCREEN_HEIGHT: scr_height = data[SIZE_BITS-1:0];
      REG_ORIENTATION:   orient = data[2:0];
      default: ;
    endcase
  endtask

  task automatic queue_touch(input int x, input int y);
    tcm_req_t touch;
    touch.raw_x = RAW_BITS'(x);
    touch.raw_y = RAW_BITS'(y);
    pending_touches.push_back(touch);
  endtask

  task automatic queue_corners();
    @(negedge clk_i);
    queue_touch(0, 0);
    queue_touch(RAW_TOP, RAW_TOP);
    queue_touch(0, RAW_TOP);
    queue_touch(RAW_TOP, 0);
    queue_touch('hAAA, 'h555);
    queue_touch(2000, 2000);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_touches.size() != 0 || start_i || expected_pixels.size() != 0);
  endtask

  initial begin
    int sent;
    int batch;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset calibration
    queue_corners();
    wait_idle();

    // swap with both mirrors, distinct ranges per axis
    write_reg(REG_RAW_MIN_X, 100);
    write_reg(REG_RAW_MAX_X, 3000);
    write_reg(REG_RAW_MIN_Y, 500);
    write_reg(REG_RAW_MAX_Y, 3500);
    write_reg(REG_ORIENTATION, 7);
    queue_corners();
    wait_idle();

    // zero ranges, zero and oversized screen, write to an unused index
    write_reg(REG_RAW_MIN_X, 2000);
    write_reg(REG_RAW_MAX_X, 2000);
    write_reg(REG_RAW_MIN_Y, RAW_TOP);
    write_reg(REG_RAW_MAX_Y, RAW_TOP);
    write_reg(REG_SCREEN_WIDTH, 0);
    write_reg(REG_SCREEN_HEIGHT, 'hFFF);
    write_reg(REG_ORIENTATION, 0);
    write_reg(REG_UNUSED, 'hFFF);
    queue_corners();
    wait_idle();

    // inverted ranges, largest and smallest screen
    write_reg(REG_RAW_MIN_X, RAW_TOP);
    write_reg(REG_RAW_MAX_X, 0);
    write_reg(REG_RAW_MIN_Y, 3000);
    write_reg(REG_RAW_MAX_Y, 1000);
    write_reg(REG_SCREEN_WIDTH, 2048);
    write_reg(REG_SCREEN_HEIGHT, 1);
    write_reg(REG_ORIENTATION, 2);
    queue_corners();
    wait_idle();

    sent = 0;
    while (sent < TARGET_TOUCHES) begin
      for (int axis = 0; axis < 2; axis++) begin
        int a;
        int b;
        int lo;
        int hi;
        a = $urandom_range(RAW_TOP, 0);
        b = $urandom_range(RAW_TOP, 0);
        case ($urandom_range(0, 9))
          0: begin lo = a; hi = a; end
          1: begin lo = (a > b) ? a : b; hi = (a > b) ? b : a; end
          2: begin lo = 0; hi = RAW_TOP; end
          default: begin lo = (a < b) ? a : b; hi = (a < b) ? b : a; end
        endcase
        write_reg((axis == 0) ? REG_RAW_MIN_X : REG_RAW_MIN_Y, lo);
        write_reg((axis == 0) ? REG_RAW_MAX_X : REG_RAW_MAX_Y, hi);
      end
      write_reg(REG_SCREEN_WIDTH, int'(pick_size()));
      write_reg(REG_SCREEN_HEIGHT, int'(pick_size()));
      write_reg(REG_ORIENTATION, $urandom_range(RAW_TOP, 0));
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, $urandom_range(RAW_TOP, 0));

      batch = $urandom_range(80, 20);
      @(negedge clk_i);
      for (int i = 0; i < batch; i++) begin
        if ($urandom_range(0, 3) != 0)
          queue_touch(int'(near_range(cal_min_x, cal_max_x)),
                      int'(near_range(cal_min_y, cal_max_y)));
        else
          queue_touch($urandom_range(RAW_TOP, 0), $urandom_range(RAW_TOP, 0));
      end
      sent += batch;
      wait_idle();
    end

    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
